// File: rtl/lclp_pkg.sv
// ----------------------------------------------------------------------------
// lclp_pkg
// Shared types, sizes and character codes of the LED command line parser.
// ----------------------------------------------------------------------------
package lclp_pkg;

  localparam int LED_COUNT    = 16;
  localparam int NIBBLE_DEPTH = 32;

  localparam int STORE_ROWS = (NIBBLE_DEPTH + 1) / 2;
  localparam int ROW_W      = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
  localparam int LED_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int COUNT_W    = $clog2(NIBBLE_DEPTH + 2);
  localparam int SET_ALL_N  = (LED_COUNT < NIBBLE_DEPTH / 2) ? LED_COUNT : NIBBLE_DEPTH / 2;

  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_F  = 8'h46;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
  } rx_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_char;
    logic [3:0] led_index;
    logic [3:0] green_level;
    logic [3:0] red_level;
    logic       last;
  } result_word_t;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[CH_0:CH_9], [CH_A:CH_F]};
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    if (c <= CH_9) begin
      d = c - CH_0;
    end else begin
      d = c - CH_A + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v <= 4'd9) begin
      return CH_0 + {4'd0, v};
    end
    return CH_A + {4'd0, v} - 8'd10;
  endfunction

endpackage

// File: rtl/led_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// led_command_line_parser_core
// Line command parser for LED settings: set and read commands over UART bytes.
// ----------------------------------------------------------------------------
// Input channel char_valid/char_ready/char_word carries one received byte and
// its line error flag; a byte with the error flag is dropped silently.
// Output channel result_valid/result_ready/result_word carries transmit
// characters and LED updates; every good byte ends with its own echo, which
// is marked by last.
// Each good byte passes to the echo state, which loads its echo into the
// output register; set-one first reads a second store row, read-one first
// reads the LED table. Set-all gives 16 updates + echo, read-all 32
// characters + echo. The result sequencer loads at most one word per cycle
// into the single output register while it is free, fed by registered memory reads.
// A new byte is taken once the echo of the previous one is loaded, even while
// that echo still waits at the output.
// When the receiver stalls the sequencer holds, and memory read data stays
// in its output register, so nothing is lost.
// Reset clears the parse mode, the nibble count and the LED table valid
// bits; the LED table reads as zero until written. No clearing pass.
// ----------------------------------------------------------------------------
module led_command_line_parser_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_ready,
  input  lclp_pkg::rx_word_t     char_word,
  output logic                  result_valid,
  input  logic                  result_ready,
  output lclp_pkg::result_word_t result_word
);

  typedef enum logic [1:0] {
    MODE_WAIT,
    MODE_SET,
    MODE_READ
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_ALL,
    ST_SET_ONE_A,
    ST_SET_ONE_B,
    ST_RD_ONE,
    ST_RD_G,
    ST_RD_R,
    ST_ECHO
  } state_t;

  state_t                           state, state_next;
  mode_t                            mode, mode_next;
  logic [lclp_pkg::COUNT_W-1:0]     count, count_next;
  logic [7:0]                       ch, ch_next;
  logic [lclp_pkg::LED_W-1:0]       led_i, led_i_next;
  logic [3:0]                       one_idx, one_idx_next;
  logic [3:0]                       one_g, one_g_next;
  logic                             zero_rd, zero_rd_next;
  logic                             rd_all, rd_all_next;
  logic                             result_valid_next;
  lclp_pkg::result_word_t           result_word_next;
  logic [lclp_pkg::LED_COUNT-1:0]   led_valid;

  logic [3:0] store_lo [lclp_pkg::STORE_ROWS];
  logic [3:0] store_hi [lclp_pkg::STORE_ROWS];
  logic [3:0] green_mem [lclp_pkg::LED_COUNT];
  logic [3:0] red_mem [lclp_pkg::LED_COUNT];

  logic                         store_we_lo, store_we_hi, store_re;
  logic [lclp_pkg::ROW_W-1:0]   store_wa, store_ra;
  logic [3:0]                   store_wd;
  logic [3:0]                   lo_q, hi_q;

  logic                         led_we, led_re;
  logic [lclp_pkg::LED_W-1:0]   led_wa, led_ra;
  logic [3:0]                   led_wg, led_wr;
  logic [3:0]                   g_q, r_q;
  logic                         v_q;

  logic       free;
  logic [7:0] c;
  logic       eol;
  logic       hv;
  logic [3:0] hval;
  logic       rd_ok;

  function automatic lclp_pkg::result_word_t mk_char(input logic [7:0] t, input logic lst);
    lclp_pkg::result_word_t w;
    w = '0;
    w.kind    = lclp_pkg::KIND_CHAR;
    w.tx_char = t;
    w.last    = lst;
    return w;
  endfunction

  function automatic lclp_pkg::result_word_t mk_update(input logic [3:0] idx,
                                                       input logic [3:0] g,
                                                       input logic [3:0] r);
    lclp_pkg::result_word_t w;
    w = '0;
    w.kind        = lclp_pkg::KIND_UPDATE;
    w.led_index   = idx;
    w.green_level = g;
    w.red_level   = r;
    return w;
  endfunction

  assign char_ready = (state == ST_IDLE);
  assign free       = !result_valid || result_ready;
  assign c          = char_word.rx_byte;
  assign eol        = c inside {lclp_pkg::CH_LF, lclp_pkg::CH_CR};
  assign hv         = lclp_pkg::is_hex(c);
  assign hval       = lclp_pkg::hex_nibble(c);
  assign rd_ok      = v_q && !zero_rd;

  always_comb begin
    state_next        = state;
    mode_next         = mode;
    count_next        = count;
    ch_next           = ch;
    led_i_next        = led_i;
    one_idx_next      = one_idx;
    one_g_next        = one_g;
    zero_rd_next      = zero_rd;
    rd_all_next       = rd_all;
    result_valid_next = result_valid && !result_ready;
    result_word_next  = result_word;
    store_we_lo       = 1'b0;
    store_we_hi       = 1'b0;
    store_wa          = '0;
    store_wd          = hval;
    store_re          = 1'b0;
    store_ra          = '0;
    led_we            = 1'b0;
    led_wa            = led_i;
    led_wg            = lo_q;
    led_wr            = hi_q;
    led_re            = 1'b0;
    led_ra            = '0;

    case (state)
      ST_IDLE: begin
        if (char_valid && !char_word.rx_error) begin
          ch_next      = c;
          state_next   = ST_ECHO;
          zero_rd_next = 1'b0;
          if (c == lclp_pkg::CH_S) begin
            mode_next  = MODE_SET;
            count_next = '0;
          end else if (c == lclp_pkg::CH_R) begin
            mode_next  = MODE_READ;
            count_next = '0;
          end else begin
            case (mode)
              MODE_SET: begin
                if (eol) begin
                  mode_next = MODE_WAIT;
                  if (count == lclp_pkg::COUNT_W'(lclp_pkg::NIBBLE_DEPTH)) begin
                    store_re   = 1'b1;
                    led_i_next = '0;
                    state_next = ST_SET_ALL;
                  end else if ((count == lclp_pkg::COUNT_W'(3)) &&
                               (lclp_pkg::NIBBLE_DEPTH >= 3)) begin
                    store_re   = 1'b1;
                    state_next = ST_SET_ONE_A;
                  end
                end else if (hv) begin
                  if (count < lclp_pkg::COUNT_W'(lclp_pkg::NIBBLE_DEPTH)) begin
                    store_wa    = lclp_pkg::ROW_W'(count >> 1);
                    store_we_lo = !count[0];
                    store_we_hi = count[0];
                  end
                  if (count < lclp_pkg::COUNT_W'(lclp_pkg::NIBBLE_DEPTH + 1)) begin
                    count_next = count + 1'b1;
                  end
                end
              end
              MODE_READ: begin
                if (eol) begin
                  if (count == lclp_pkg::COUNT_W'(1)) begin
                    store_re   = 1'b1;
                    mode_next  = MODE_WAIT;
                    state_next = ST_RD_ONE;
                  end else if (count == '0) begin
                    mode_next   = MODE_WAIT;
                    led_i_next  = '0;
                    rd_all_next = 1'b1;
                    led_re      = 1'b1;
                    state_next  = ST_RD_G;
                  end
                end else if (hv) begin
                  if (count == '0) begin
                    store_we_lo = 1'b1;
                  end
                  if (count < lclp_pkg::COUNT_W'(2)) begin
                    count_next = count + 1'b1;
                  end
                end else begin
                  mode_next = MODE_WAIT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_SET_ALL: begin
        if (free) begin
          result_valid_next = 1'b1;
          result_word_next  = mk_update(4'(led_i), lo_q, hi_q);
          led_we            = 1'b1;
          if (led_i == lclp_pkg::LED_W'(lclp_pkg::SET_ALL_N - 1)) begin
            state_next = ST_ECHO;
          end else begin
            led_i_next = led_i + 1'b1;
            store_re   = 1'b1;
            store_ra   = lclp_pkg::ROW_W'(32'(led_i) + 1);
          end
        end
      end
      ST_SET_ONE_A: begin
        one_idx_next = lo_q;
        one_g_next   = hi_q;
        store_re     = 1'b1;
        store_ra     = lclp_pkg::ROW_W'(1);
        state_next   = ST_SET_ONE_B;
      end
      ST_SET_ONE_B: begin
        if (32'(one_idx) < lclp_pkg::LED_COUNT) begin
          if (free) begin
            result_valid_next = 1'b1;
            result_word_next  = mk_update(one_idx, one_g, lo_q);
            led_we            = 1'b1;
            led_wa            = one_idx[lclp_pkg::LED_W-1:0];
            led_wg            = one_g;
            led_wr            = lo_q;
            state_next        = ST_ECHO;
          end
        end else begin
          state_next = ST_ECHO;
        end
      end
      ST_RD_ONE: begin
        rd_all_next = 1'b0;
        if (32'(lo_q) < lclp_pkg::LED_COUNT) begin
          led_re       = 1'b1;
          led_ra       = lo_q[lclp_pkg::LED_W-1:0];
          zero_rd_next = 1'b0;
        end else begin
          zero_rd_next = 1'b1;
        end
        state_next = ST_RD_G;
      end
      ST_RD_G: begin
        if (free) begin
          result_valid_next = 1'b1;
          result_word_next  = mk_char(lclp_pkg::hex_char(rd_ok ? g_q : 4'd0), 1'b0);
          state_next        = ST_RD_R;
        end
      end
      ST_RD_R: begin
        if (free) begin
          result_valid_next = 1'b1;
          result_word_next  = mk_char(lclp_pkg::hex_char(rd_ok ? r_q : 4'd0), 1'b0);
          if (rd_all && (led_i != lclp_pkg::LED_W'(lclp_pkg::LED_COUNT - 1))) begin
            led_i_next = led_i + 1'b1;
            led_re     = 1'b1;
            led_ra     = led_i + 1'b1;
            state_next = ST_RD_G;
          end else begin
            state_next = ST_ECHO;
          end
        end
      end
      ST_ECHO: begin
        if (free) begin
          result_valid_next = 1'b1;
          result_word_next  = mk_char(ch, 1'b1);
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= MODE_WAIT;
      count        <= '0;
      result_valid <= 1'b0;
      led_valid    <= '0;
      zero_rd      <= 1'b0;
      rd_all       <= 1'b0;
    end else begin
      state        <= state_next;
      mode         <= mode_next;
      count        <= count_next;
      result_valid <= result_valid_next;
      zero_rd      <= zero_rd_next;
      rd_all       <= rd_all_next;
      if (led_we) begin
        led_valid[led_wa] <= 1'b1;
      end
    end
    ch          <= ch_next;
    led_i       <= led_i_next;
    one_idx     <= one_idx_next;
    one_g       <= one_g_next;
    result_word <= result_word_next;
  end

  always_ff @(posedge clk) begin
    if (store_we_lo) begin
      store_lo[store_wa] <= store_wd;
    end
    if (store_we_hi) begin
      store_hi[store_wa] <= store_wd;
    end
    if (store_re) begin
      lo_q <= store_lo[store_ra];
      hi_q <= store_hi[store_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (led_we) begin
      green_mem[led_wa] <= led_wg;
      red_mem[led_wa]   <= led_wr;
    end
    if (led_re) begin
      g_q <= green_mem[led_ra];
      r_q <= red_mem[led_ra];
      v_q <= led_valid[led_ra];
    end
  end

  a_error_dropped: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready && char_word.rx_error) |=>
      (state == ST_IDLE) && $stable(mode) && $stable(count))
    else $error("error byte changed parser state");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count <= lclp_pkg::COUNT_W'(lclp_pkg::NIBBLE_DEPTH + 1)))
    else $error("nibble count past saturation");

  a_update_word: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_word.kind == lclp_pkg::KIND_UPDATE)) |->
      (!result_word.last && (32'(result_word.led_index) < lclp_pkg::LED_COUNT)))
    else $error("bad LED update word");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready && !char_word.rx_error) |=> (state != ST_IDLE))
    else $error("accepted byte produced no echo sequence");

endmodule
